### hdl/button_debounce_hold_repeat_top_assert.svh
// Assertion macros shared by the button debounce block
`ifndef BUTTON_DEBOUNCE_HOLD_REPEAT_TOP_ASSERT_SVH
`define BUTTON_DEBOUNCE_HOLD_REPEAT_TOP_ASSERT_SVH

// check the consequent in the same cycle as the antecedent
`define BDHR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check the consequent in the cycle after the antecedent
`define BDHR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bdhr_pkg.sv
// Shared types and constants for the button debounce, long-press and repeat block
package bdhr_pkg;

  localparam int LEVELS_W  = 6;
  localparam int DEB_W     = 8;
  localparam int HOLD_W    = 16;
  localparam int KIND_W    = 2;
  localparam int INDEX_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [KIND_W-1:0] EV_SINGLE  = 2'd0;
  localparam logic [KIND_W-1:0] EV_HOLD    = 2'd1;
  localparam logic [KIND_W-1:0] EV_RELEASE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_SEEK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_VOL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_OTHER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_MASK = 3'd5;

  localparam logic [DEB_W-1:0]    DEBOUNCE_RESET     = 8'd100;
  localparam logic [HOLD_W-1:0]   LONG_PRESS_RESET   = 16'd800;
  localparam logic [HOLD_W-1:0]   REPEAT_SEEK_RESET  = 16'd1000;
  localparam logic [HOLD_W-1:0]   REPEAT_VOL_RESET   = 16'd500;
  localparam logic [HOLD_W-1:0]   REPEAT_OTHER_RESET = 16'hFFFF;
  localparam logic [LEVELS_W-1:0] RELEASE_MASK_RESET = 6'd10;

  localparam int BTN_SEEK_LEFT  = 1;
  localparam int BTN_SEEK_RIGHT = 3;
  localparam int BTN_VOL_DOWN   = 4;
  localparam int BTN_VOL_UP     = 5;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
  } lane_ev_t;

endpackage

### hdl/button_debounce_hold_repeat_top.sv
// Top level: config registers, one lane per button and the event merge stage
// Pipeline: on acceptance the events of a tick go into the pending mask register; from there
//   each result moves into the output register in turn whenever the output is not stalled.
// Throughput: one result per cycle from the merge stage while the output is not stalled; the
//   input is stalled until the last pending result of a tick moves out (at most BUTTONS per tick).
// Reset (synchronous, rst high): every button idle with counters cleared, registers at
//   their default values, no pending events, output empty.
module button_debounce_hold_repeat_top import bdhr_pkg::*; #(
  parameter int BUTTONS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [LEVELS_W-1:0]   pressed_levels,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [INDEX_W-1:0]    button_index,
  output logic [KIND_W-1:0]     event_kind,
  output logic                  last_event,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DEB_W-1:0]       debounce_ticks;
  logic [HOLD_W-1:0]      long_press_ticks;
  logic [HOLD_W-1:0]      repeat_seek_ticks;
  logic [HOLD_W-1:0]      repeat_volume_ticks;
  logic [HOLD_W-1:0]      repeat_other_ticks;
  logic [LEVELS_W-1:0]    release_event_mask;

  lane_ev_t [BUTTONS-1:0] events;
  logic                   accept;
  logic                   busy;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks      <= DEBOUNCE_RESET;
      long_press_ticks    <= LONG_PRESS_RESET;
      repeat_seek_ticks   <= REPEAT_SEEK_RESET;
      repeat_volume_ticks <= REPEAT_VOL_RESET;
      repeat_other_ticks  <= REPEAT_OTHER_RESET;
      release_event_mask  <= RELEASE_MASK_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEBOUNCE:     debounce_ticks      <= cfg_data[DEB_W-1:0];
        CFG_LONG_PRESS:   long_press_ticks    <= cfg_data[HOLD_W-1:0];
        CFG_REPEAT_SEEK:  repeat_seek_ticks   <= cfg_data[HOLD_W-1:0];
        CFG_REPEAT_VOL:   repeat_volume_ticks <= cfg_data[HOLD_W-1:0];
        CFG_REPEAT_OTHER: repeat_other_ticks  <= cfg_data[HOLD_W-1:0];
        CFG_RELEASE_MASK: release_event_mask  <= cfg_data[LEVELS_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
    logic              pressed;
    logic              release_en;
    logic [HOLD_W-1:0] repeat_ticks;

    if (i < LEVELS_W) begin : g_wired
      assign pressed    = pressed_levels[i];
      assign release_en = release_event_mask[i];
    end else begin : g_spare
      assign pressed    = 1'b0;
      assign release_en = 1'b0;
    end

    if (i == BTN_SEEK_LEFT || i == BTN_SEEK_RIGHT) begin : g_seek
      assign repeat_ticks = repeat_seek_ticks;
    end else if (i == BTN_VOL_DOWN || i == BTN_VOL_UP) begin : g_vol
      assign repeat_ticks = repeat_volume_ticks;
    end else begin : g_other
      assign repeat_ticks = repeat_other_ticks;
    end

    bdhr_lane u_lane (
      .clk              (clk),
      .rst              (rst),
      .step             (accept),
      .pressed          (pressed),
      .debounce_ticks   (debounce_ticks),
      .long_press_ticks (long_press_ticks),
      .repeat_ticks     (repeat_ticks),
      .release_en       (release_en),
      .ev               (events[i])
    );
  end

  bdhr_merge #(
    .BUTTONS (BUTTONS)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .events       (events),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .button_index (button_index),
    .event_kind   (event_kind),
    .last_event   (last_event)
  );

endmodule

### hdl/bdhr_lane.sv
// One button lane: debounce, short and long press, hold repeat
module bdhr_lane import bdhr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              pressed,
  input  logic [DEB_W-1:0]  debounce_ticks,
  input  logic [HOLD_W-1:0] long_press_ticks,
  input  logic [HOLD_W-1:0] repeat_ticks,
  input  logic              release_en,
  output lane_ev_t          ev
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRESS_DEB,
    PH_SHORT,
    PH_LONG,
    PH_RELEASE_DEB
  } phase_t;

  phase_t            phase, phase_next;
  logic              was_long, was_long_next;
  logic [DEB_W-1:0]  debounce_count, debounce_count_next;
  logic [HOLD_W-1:0] hold_count, hold_count_next;
  logic [HOLD_W-1:0] hold_period, hold_period_next;

  logic [DEB_W-1:0]  deb_inc;
  logic [HOLD_W-1:0] hold_inc;
  logic              deb_done;

  assign deb_inc  = (debounce_count == '1) ? debounce_count : debounce_count + DEB_W'(1);
  assign hold_inc = (hold_count == '1) ? hold_count : hold_count + HOLD_W'(1);
  assign deb_done = deb_inc > debounce_ticks;

  always_comb begin
    phase_next          = phase;
    was_long_next       = was_long;
    debounce_count_next = debounce_count;
    hold_count_next     = hold_count;
    hold_period_next    = hold_period;
    ev.valid            = 1'b0;
    ev.kind             = EV_SINGLE;
    case (phase)
      PH_PRESS_DEB: begin
        if (!pressed) begin
          debounce_count_next = '0;
          phase_next          = PH_IDLE;
        end else begin
          debounce_count_next = deb_inc;
          if (deb_done) begin
            hold_count_next = '0;
            phase_next      = PH_SHORT;
          end
        end
      end
      PH_SHORT: begin
        if (!pressed) begin
          debounce_count_next = '0;
          was_long_next       = 1'b0;
          phase_next          = PH_RELEASE_DEB;
        end else begin
          hold_count_next = hold_inc;
          if (hold_inc > long_press_ticks) begin
            phase_next = PH_LONG;
          end
        end
      end
      PH_LONG: begin
        if (!pressed) begin
          debounce_count_next = '0;
          was_long_next       = 1'b1;
          phase_next          = PH_RELEASE_DEB;
        end else begin
          hold_count_next = hold_inc;
          if (hold_inc > hold_period) begin
            hold_count_next  = '0;
            hold_period_next = repeat_ticks;
            ev.valid         = 1'b1;
            ev.kind          = EV_HOLD;
          end
        end
      end
      PH_RELEASE_DEB: begin
        if (pressed) begin
          debounce_count_next = '0;
          phase_next          = was_long ? PH_LONG : PH_SHORT;
        end else begin
          debounce_count_next = deb_inc;
          if (deb_done) begin
            if (!was_long) begin
              ev.valid = 1'b1;
              ev.kind  = EV_SINGLE;
            end else if (release_en) begin
              ev.valid = 1'b1;
              ev.kind  = EV_RELEASE;
            end
            hold_count_next = '0;
            phase_next      = PH_IDLE;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (pressed) begin
          hold_period_next    = long_press_ticks;
          debounce_count_next = '0;
          phase_next          = PH_PRESS_DEB;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      was_long       <= 1'b0;
      debounce_count <= '0;
      hold_count     <= '0;
      hold_period    <= '0;
    end else if (step) begin
      phase          <= phase_next;
      was_long       <= was_long_next;
      debounce_count <= debounce_count_next;
      hold_count     <= hold_count_next;
      hold_period    <= hold_period_next;
    end
  end

endmodule

### hdl/bdhr_merge.sv
// Merge stage: serialise lane events in ascending button order into the output register
module bdhr_merge import bdhr_pkg::*; #(
  parameter int BUTTONS = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  lane_ev_t [BUTTONS-1:0]   events,
  output logic                     busy,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [INDEX_W-1:0]       button_index,
  output logic [KIND_W-1:0]        event_kind,
  output logic                     last_event
);

`include "button_debounce_hold_repeat_top_assert.svh"

  logic [BUTTONS-1:0]             mask;
  logic [BUTTONS-1:0][KIND_W-1:0] kinds;
  logic [BUTTONS-1:0]             ev_mask;
  logic [BUTTONS-1:0]             pick;
  logic [BUTTONS-1:0]             rest;
  logic [INDEX_W-1:0]             pick_index;
  logic [KIND_W-1:0]              pick_kind;
  logic                           pop;

  assign pick = mask & (~mask + BUTTONS'(1));
  assign rest = mask & ~pick;
  assign pop  = (mask != '0) && (!out_valid || !out_stall);
  assign busy = (mask != '0) && !(pop && rest == '0);

  always_comb begin
    pick_index = '0;
    pick_kind  = '0;
    for (int i = 0; i < BUTTONS; i++) begin
      ev_mask[i] = events[i].valid;
      if (pick[i]) begin
        pick_index = pick_index | INDEX_W'(i);
        pick_kind  = pick_kind | kinds[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        mask <= ev_mask;
      end else if (pop) begin
        mask <= rest;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < BUTTONS; i++) begin
        kinds[i] <= events[i].kind;
      end
    end
    if (pop) begin
      button_index <= pick_index;
      event_kind   <= pick_kind;
      last_event   <= (rest == '0);
    end
  end

  `BDHR_ASSERT_NEXT(a_drain, mask != '0 && !out_valid, out_valid, "pending item not moved out")
  `BDHR_ASSERT_NEXT(a_hold_stalled, out_valid && out_stall && mask != '0, $stable(mask),
                    "pending events changed while output stalled")
  `BDHR_ASSERT_NEXT(a_last_empties, pop && rest == '0 && !accept, mask == '0,
                    "events left after last item of a tick")

endmodule
